### rtl/tempa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempa_pkg: shared types, constants and functions
// Register indexes, reset values, the result and segment types and the segment table
// used by the temperature alarm block.
// ----------------------------------------------------------------------------
package tempa_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_WRAP  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_INTERVAL = 2'd2;

   localparam logic [7:0]  THRESHOLD_START_RST = 8'd40;
   localparam logic [7:0]  THRESHOLD_WRAP_RST  = 8'd150;
   localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd140;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_BUMP = 1'b1;

   // Outcome of one transaction before segment encoding
   typedef struct packed {
      logic       buzzer;
      logic       alarm_latched;
      logic [7:0] shown_value;
   } result_type;

   typedef struct packed {
      logic [7:0] hundreds;
      logic [7:0] tens;
      logic [7:0] units;
   } segments_type;

   // Common-anode (active-low) codes for digits 0..9
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hC0;
      endcase
      return code;
   endfunction

endpackage

### rtl/tempa_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempa_core: configuration registers and alarm state
// Applies one tick or bump per accepted transaction, runs the alarm rule and
// presents the outcome of the transaction being accepted.
// ----------------------------------------------------------------------------
module tempa_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tempa_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tempa_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                 step,
   input  logic                                 kind,
   input  logic [7:0]                           adc_sample,
   input  logic                                 button,
   output tempa_pkg::result_type                result
);
   import tempa_pkg::*;

   logic [7:0]  thr_wrap_ff;
   logic [15:0] interval_ff;
   logic [7:0]  threshold_ff,  threshold_in;
   logic [7:0]  latched_ff,    latched_in;
   logic [7:0]  display_ff,    display_in;
   logic [15:0] tick_ff,       tick_in;
   logic        alarm_ff,      alarm_in;
   logic        buzzer_in;

   logic [15:0] tick_inc;
   logic [7:0]  thr_inc;

   always_comb begin
      tick_inc     = tick_ff + 16'd1;
      thr_inc      = threshold_ff + 8'd1;
      threshold_in = threshold_ff;
      latched_in   = latched_ff;
      display_in   = display_ff;
      tick_in      = tick_ff;
      if (kind == KIND_TICK) begin
         if (tick_inc == interval_ff) begin
            latched_in = adc_sample;
            display_in = adc_sample;
            tick_in    = '0;
         end else begin
            tick_in = tick_inc;
         end
      end else begin
         display_in   = thr_inc;
         threshold_in = (thr_inc == thr_wrap_ff) ? 8'd1 : thr_inc;
      end

      alarm_in  = alarm_ff;
      buzzer_in = 1'b0;
      priority if (latched_in >= threshold_in) begin
         buzzer_in = 1'b1;
         alarm_in  = 1'b1;
      end else if (!alarm_ff) begin
         buzzer_in = 1'b0;
      end else if (button) begin
         buzzer_in = 1'b1;
      end else begin
         // button released: drop the latch
         buzzer_in = 1'b0;
         alarm_in  = 1'b0;
      end
   end

   assign result = '{buzzer: buzzer_in, alarm_latched: alarm_in, shown_value: display_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_wrap_ff  <= THRESHOLD_WRAP_RST;
         interval_ff  <= SAMPLE_INTERVAL_RST;
         threshold_ff <= THRESHOLD_START_RST;
         latched_ff   <= '0;
         display_ff   <= '0;
         tick_ff      <= '0;
         alarm_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD_START: threshold_ff <= csr_wdata[7:0];
            CSR_THRESHOLD_WRAP:  thr_wrap_ff <= csr_wdata[7:0];
            CSR_SAMPLE_INTERVAL: interval_ff <= csr_wdata;
            default: ;
         endcase
      end else if (step) begin
         threshold_ff <= threshold_in;
         latched_ff   <= latched_in;
         display_ff   <= display_in;
         tick_ff      <= tick_in;
         alarm_ff     <= alarm_in;
      end
   end

endmodule

### rtl/tempa_seg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempa_seg: three-digit seven-segment encoder
// Splits an 8-bit value into hundreds, tens and units and maps each digit
// to its active-low segment code.
// ----------------------------------------------------------------------------
module tempa_seg (
   input  logic [7:0]              value,
   output tempa_pkg::segments_type segs
);
   import tempa_pkg::*;

   logic [1:0]  hundreds;
   logic [6:0]  rest;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [3:0]  units;
   logic [6:0]  tens_x10;

   always_comb begin
      priority if (value >= 8'd200) begin
         hundreds = 2'd2;
         rest     = 7'(value - 8'd200);
      end else if (value >= 8'd100) begin
         hundreds = 2'd1;
         rest     = 7'(value - 8'd100);
      end else begin
         hundreds = 2'd0;
         rest     = value[6:0];
      end
      // rest / 10 as rest * 205 >> 11, exact below 100
      tens_prod = 15'(rest) * 15'd205;
      tens      = tens_prod[14:11];
      tens_x10  = 7'(tens) * 7'd10;
      units     = 4'(rest - tens_x10);
   end

   assign segs = '{hundreds: seg_code({2'b00, hundreds}),
                   tens:     seg_code(tens),
                   units:    seg_code(units)};

endmodule

### rtl/temperature_alarm_with_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_alarm_with_display: threshold alarm with 3-digit display codes
// Top level: stream ports, configuration port and the result register.
// ----------------------------------------------------------------------------
// Each transaction on req_ is a timer tick carrying an ADC sample (tuser 0)
// or a threshold bump (tuser 1) and yields exactly one result on rsp_ in the
// next cycle. The block takes one transaction per clock: the state update,
// alarm rule and digit split all sit ahead of the single result register,
// and req_tready stays high while that register is empty or being drained.
// Writes on csr_ take effect at once; writing threshold_start also reloads
// the threshold. Write configuration only while no transaction is pending.
module temperature_alarm_with_display (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tempa_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [tempa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // adc_sample[7:0], button[8], zeros
   input  logic                              req_tuser,  // kind
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata   // buzzer, alarm_latched,
                                                         // shown_value, hundreds, tens, units
);
   import tempa_pkg::*;

   logic         step;
   result_type   result;
   segments_type segs;
   logic         rsp_valid_ff;
   logic [33:0]  rsp_data_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   tempa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .step       (step),
      .kind       (req_tuser),
      .adc_sample (req_tdata[7:0]),
      .button     (req_tdata[8]),
      .result     (result)
   );

   tempa_seg u_seg (
      .value (result.shown_value),
      .segs  (segs)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: hold while stalled, load on each accepted transaction
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {segs.units, segs.tens, segs.hundreds, result.shown_value,
                         result.alarm_latched, result.buzzer};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

endmodule

### dv/tempa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempa_checker: result checker for the temperature alarm block
// Watches the configuration port and both stream channels, keeps its own
// copy of the alarm state, predicts one display reading per accepted request
// and compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module tempa_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tempa_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tempa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [15:0]                         req_tdata,
   input  logic                                req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [39:0]                         rsp_tdata,
   output int unsigned                         mismatch_count,
   output int unsigned                         readings_pending
);
   import tempa_pkg::*;

   // Response word, lowest field last
   typedef struct packed {
      logic [5:0] pad;
      logic [7:0] units;
      logic [7:0] tens;
      logic [7:0] hundreds;
      logic [7:0] shown;
      logic       alarm;
      logic       buzzer;
   } reading_type;

   localparam logic [7:0] DIGIT_GLYPH [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   logic [7:0]  cfg_start;
   logic [7:0]  cfg_wrap;
   logic [15:0] cfg_interval;
   logic [7:0]  thr;
   logic [7:0]  held_sample;
   logic [7:0]  on_display;
   logic [15:0] tick_cnt;
   logic        alarm_on;
   logic        buzzer_on;
   reading_type expected_readings[$];

   function automatic reading_type step_alarm(input logic kind, input logic [7:0] sample,
                                              input logic button);
      reading_type r;
      int unsigned v;
      if (kind == KIND_TICK) begin
         tick_cnt = tick_cnt + 16'd1;
         if (tick_cnt == cfg_interval) begin
            held_sample = sample;
            on_display  = sample;
            tick_cnt    = '0;
         end
      end else begin
         thr        = thr + 8'd1;
         on_display = thr;
         if (thr == cfg_wrap) thr = 8'd1;
      end
      if (held_sample >= thr) begin
         buzzer_on = 1'b1;
         alarm_on  = 1'b1;
      end else if (!alarm_on) begin
         buzzer_on = 1'b0;
      end else if (button) begin
         buzzer_on = 1'b1;
      end else begin
         buzzer_on = 1'b0;
         alarm_on  = 1'b0;
      end
      v          = on_display;
      r.pad      = '0;
      r.buzzer   = buzzer_on;
      r.alarm    = alarm_on;
      r.shown    = on_display;
      r.hundreds = DIGIT_GLYPH[(v / 100) % 10];
      r.tens     = DIGIT_GLYPH[(v % 100) / 10];
      r.units    = DIGIT_GLYPH[v % 10];
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (reset) begin
         cfg_start    = THRESHOLD_START_RST;
         cfg_wrap     = THRESHOLD_WRAP_RST;
         cfg_interval = SAMPLE_INTERVAL_RST;
         thr          = THRESHOLD_START_RST;
         held_sample  = '0;
         on_display   = '0;
         tick_cnt     = '0;
         alarm_on     = 1'b0;
         buzzer_on    = 1'b0;
         expected_readings.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = reading_type'(rsp_tdata);
            if (expected_readings.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected transaction, expected none, actual 0x%010h",
                        $time, rsp_tdata);
            end else begin
               want = expected_readings.pop_front();
               compare_field("buzzer", {7'd0, want.buzzer}, {7'd0, got.buzzer});
               compare_field("alarm_latched", {7'd0, want.alarm}, {7'd0, got.alarm});
               compare_field("shown_value", want.shown, got.shown);
               compare_field("hundreds_segments", want.hundreds, got.hundreds);
               compare_field("tens_segments", want.tens, got.tens);
               compare_field("units_segments", want.units, got.units);
               compare_field("padding", {2'd0, want.pad}, {2'd0, got.pad});
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_THRESHOLD_START: begin
                  cfg_start = csr_wdata[7:0];
                  thr       = csr_wdata[7:0];
               end
               CSR_THRESHOLD_WRAP:  cfg_wrap = csr_wdata[7:0];
               CSR_SAMPLE_INTERVAL: cfg_interval = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_readings.push_back(step_alarm(req_tuser, req_tdata[7:0], req_tdata[8]));
      end
      readings_pending = expected_readings.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the temperature alarm block
// Drives ticks and threshold bumps with random gaps and back-pressure over
// several register settings, including one long receiver stall.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb;
   import tempa_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int unsigned           HOLD_CYCLES  = 90;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata  = '0;   // adc_sample[7:0], button[8], zeros
   logic                  req_tuser  = 1'b0; // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;         // buzzer, alarm_latched, shown_value,
                                             // hundreds, tens, units, zeros
   int unsigned           mismatch_count;
   int unsigned           readings_pending;
   int unsigned           send_idle_pct = 0;
   int unsigned           recv_idle_pct = 0;
   logic                  long_hold_armed = 1'b0;

   always #6 clock = ~clock;

   temperature_alarm_with_display dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tempa_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   // Response side: random back-pressure, plus one long hold when armed
   initial begin : rsp_side
      int unsigned hold_left;
      logic        hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic kind, input logic [7:0] sample, input logic button);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, button, sample};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (readings_pending != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_alarm_config(input logic [7:0] start, input logic [7:0] wrap,
                                   input logic [15:0] interval);
      drain();
      csr_write(CSR_THRESHOLD_WRAP, {8'd0, wrap});
      csr_write(CSR_SAMPLE_INTERVAL, interval);
      csr_write(CSR_THRESHOLD_START, {8'd0, start});
   endtask

   task automatic send_random(input int unsigned bump_pct, input logic [7:0] band_hi);
      logic       kind;
      logic [7:0] sample;
      logic       button;
      kind   = ($urandom_range(99) < bump_pct) ? KIND_BUMP : KIND_TICK;
      sample = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(band_hi));
      button = ($urandom_range(99) < 75);
      send_item(kind, sample, button);
   endtask

   task automatic run_phase(input logic [7:0] start, input logic [7:0] wrap,
                            input logic [15:0] interval, input int unsigned sidle,
                            input int unsigned ridle, input logic [7:0] band_hi,
                            input logic arm_hold);
      set_alarm_config(start, wrap, interval);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      // start the long receiver stall while requests keep coming
      if (arm_hold) long_hold_armed = 1'b1;
      repeat (260) send_random(15, band_hi);
   endtask

   initial begin : watchdog
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: bump from the default start
      send_item(KIND_BUMP, 8'd0, 1'b1);

      // Latch every tick; exercise set, hold, clear and the wrap to one
      set_alarm_config(8'd148, 8'd150, 16'd1);
      csr_write(CSR_UNMAPPED, 16'hFFFF);
      send_item(KIND_TICK, 8'd255, 1'b1);
      send_item(KIND_TICK, 8'd0, 1'b1);
      send_item(KIND_TICK, 8'd0, 1'b0);
      send_item(KIND_TICK, 8'd147, 1'b1);
      send_item(KIND_TICK, 8'd148, 1'b0);
      send_item(KIND_BUMP, 8'd0, 1'b1);
      send_item(KIND_BUMP, 8'd0, 1'b0);
      send_item(KIND_TICK, 8'd0, 1'b0);
      send_item(KIND_TICK, 8'd1, 1'b1);
      send_item(KIND_TICK, 8'd100, 1'b0);

      // 8-bit overflow landing on a wrap limit of zero
      set_alarm_config(8'd255, 8'd0, 16'd1);
      send_item(KIND_BUMP, 8'd170, 1'b1);

      // Overflow to a zero threshold: every sample alarms
      set_alarm_config(8'd255, 8'd200, 16'd1);
      send_item(KIND_BUMP, 8'd85, 1'b0);
      send_item(KIND_TICK, 8'd0, 1'b0);
      send_item(KIND_TICK, 8'd0, 1'b0);

      // Wrap limit below the threshold: climb without wrapping
      set_alarm_config(8'd200, 8'd100, 16'd1);
      send_item(KIND_BUMP, 8'd0, 1'b1);
      send_item(KIND_BUMP, 8'd0, 1'b1);
      send_item(KIND_TICK, 8'd9, 1'b0);
      send_item(KIND_TICK, 8'd99, 1'b1);
      send_item(KIND_TICK, 8'd210, 1'b0);

      // Intervals never shrink below the running count here
      run_phase(8'd40, 8'd60, 16'd1, 36, 77, 8'd68, 1'b0);
      run_phase(8'd100, 8'd110, 16'd1, 77, 36, 8'd120, 1'b0);
      run_phase(8'd250, 8'd5, 16'd2, 0, 0, 8'd10, 1'b1);
      run_phase(8'd0, 8'd255, 16'd2, 36, 77, 8'd255, 1'b0);
      run_phase(8'd255, 8'd1, 16'd3, 77, 36, 8'd8, 1'b0);
      run_phase(8'd130, 8'd150, 16'd4, 0, 0, 8'd160, 1'b0);

      set_alarm_config(8'd50, 8'd60, 16'hFFFF);
      repeat (12) send_random(25, 8'd70);

      drain();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && readings_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
